// ===== hdl/dvrt_pkg.sv =====
// Shared codes and port widths for the distance-vector route table.
`timescale 1ns / 1ps
package dvrt_pkg;

  // action codes carried in s_tuser
  localparam logic [1:0] ACT_LINK     = 2'd0;
  localparam logic [1:0] ACT_CONVERGE = 2'd1;
  localparam logic [1:0] ACT_QUERY    = 2'd2;

  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;
  localparam int ACT_W    = 2;
  localparam int CFG_W    = 5;

endpackage

// ===== hdl/dvrt_route_mem.sv =====
// Route memory: one write port, two registered read ports.
`timescale 1ns / 1ps
module dvrt_route_mem #(
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/distance_vector_route_table.sv =====
// Top level of the distance-vector route table (all-pairs Bellman-Ford).
`timescale 1ns / 1ps
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: node_a, node_b, link_cost, link_present
// m_*       out  m_tvalid/m_tready  tuser: reachable; tdata: path_cost, next_hop, path_entries
// cfg_*     in   cfg_wen            cfg_wdata: node_count
//
// Steps: a link item makes two writes through the single link memory write
// port; a query reads the route memory into a registered result. A converge
// item first rebuilds the route memory from the link memory, then sweeps over
// every node pair, relaxing each neighbor pair over all destination nodes,
// sweeps repeating until one makes no change; the read-modify-write of one
// route entry through the registered-read route memory sets the pace.
// Reset (rst, synchronous) starts a pass over every link memory entry that
// fills the link memory with its empty topology; no item is taken meanwhile.
// A new item is taken only when the block is idle and the output register is
// free or being emptied in the same cycle.
module distance_vector_route_table #(
  parameter int MAX_NODES = 16,
  parameter int COST_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dvrt_pkg::S_DATA_W-1:0] s_tdata,  // node_a, node_b, link_cost, link_present
  input  logic [dvrt_pkg::ACT_W-1:0]    s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dvrt_pkg::M_DATA_W-1:0] m_tdata,  // path_cost, next_hop, path_entries
  output logic [0:0]                    m_tuser,  // reachable
  input  logic                          cfg_wen,
  input  logic [dvrt_pkg::CFG_W-1:0]    cfg_wdata // node_count
);
  import dvrt_pkg::*;

  localparam int NB  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int PB  = 2 * NB;
  localparam int RW  = COST_BITS + NB;
  localparam int LW  = $clog2(MAX_NODES + 1);

  typedef struct packed {
    logic                 inf;
    logic [RW-1:0]        cost;
    logic [NB-1:0]        next;
    logic [LW-1:0]        len;
    logic [MAX_NODES-1:0] mask;  // nodes on the path list
  } route_t;

  typedef struct packed {
    logic                 on;
    logic [COST_BITS-1:0] cost;
  } link_t;

  localparam int RTW = $bits(route_t);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LINK2, ST_QWAIT, ST_BUILD, ST_BUILD_END,
    ST_PAIR_RD, ST_PAIR_EV, ST_J_RD, ST_J_EV
  } state_t;

  state_t state;

  // input fields
  logic [3:0] node_a, node_b;
  logic [7:0] link_cost;
  logic       link_present;
  assign node_a       = s_tdata[3:0];
  assign node_b       = s_tdata[7:4];
  assign link_cost    = s_tdata[15:8];
  assign link_present = s_tdata[16];

  logic [CFG_W-1:0] node_count;
  logic [NW-1:0]    n;
  assign n = ({3'b0, node_count} > 8'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(node_count);

  logic [PB-1:0] idx, ba, link2_addr;
  logic          bv;
  link_t         link2_data;
  logic [NB-1:0] n1, n2, j;
  logic          changed;
  logic [RW-1:0] c12;
  logic [NB-1:0] hop;
  logic          q_ok;

  // link memory
  link_t         link_mem [2**PB];
  link_t         link_rdata, link_wdata;
  logic          link_we;
  logic [PB-1:0] link_waddr, link_raddr;

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[link_raddr];
  end

  // route memory
  logic          r_we;
  logic [PB-1:0] r_waddr, ra_addr, rb_addr;
  route_t        r_wdata, rd_a, rd_b;
  logic [RTW-1:0] rd_a_raw, rd_b_raw;

  dvrt_route_mem #(.WIDTH(RTW), .ADDR_W(PB)) u_route_mem (
    .clk     (clk),
    .we      (r_we),
    .waddr   (r_waddr),
    .wdata   (r_wdata),
    .raddr_a (ra_addr),
    .raddr_b (rb_addr),
    .rdata_a (rd_a_raw),
    .rdata_b (rd_b_raw)
  );
  assign rd_a = route_t'(rd_a_raw);
  assign rd_b = route_t'(rd_b_raw);

  logic accept, link_ok;
  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign link_ok  = (int'(node_a) < MAX_NODES) && (int'(node_b) < MAX_NODES)
                    && (node_a != node_b);

  // build: direct links only, nodes at or above n cut off
  logic [NB-1:0] bi, bj;
  logic          b_in;
  route_t        b_word;
  assign bi   = ba[PB-1:NB];
  assign bj   = ba[NB-1:0];
  assign b_in = (NW'(bi) < n) && (NW'(bj) < n) && link_rdata.on;
  always_comb begin
    b_word      = '0;
    b_word.inf  = !b_in;
    if (b_in) begin
      b_word.cost = RW'(link_rdata.cost);
      b_word.next = bj;
      b_word.len  = LW'(1);
      b_word.mask = MAX_NODES'(1) << bj;
    end
  end

  // relaxation of (n1, j) through neighbor n2
  logic          blocked, better, upd, dirty;
  logic [RW-1:0] cand;
  route_t        relax_word;
  assign blocked = rd_b.inf || rd_b.mask[n1] || rd_b.mask[n2];
  assign cand    = rd_b.cost + c12;
  assign better  = rd_a.inf || (cand < rd_a.cost) || ((cand == rd_a.cost) && (rd_a.next > hop));
  assign upd     = !blocked && better;
  // sweep has changed something, this cycle's update included
  assign dirty   = changed || ((state == ST_J_EV) && upd);
  always_comb begin
    relax_word.inf  = 1'b0;
    relax_word.cost = cand;
    relax_word.next = hop;
    relax_word.len  = rd_b.len + LW'(1);
    relax_word.mask = rd_b.mask | (MAX_NODES'(1) << n2);
  end

  // query result word
  logic [M_DATA_W-1:0] q_data;
  always_comb begin
    q_data = '0;
    if (q_ok) begin
      q_data[20:16] = 5'(rd_a.len);
      if (!rd_a.inf) begin
        q_data[11:0]  = (32'(rd_a.cost) > 32'd4095) ? 12'hFFF : 12'(rd_a.cost);
        q_data[15:12] = 4'(rd_a.next);
      end
    end
  end

  logic last_j, last_n2, last_n1, nbr;
  assign last_j  = (NW'(j) + NW'(1)) == n;
  assign last_n2 = (NW'(n2) + NW'(1)) == n;
  assign last_n1 = (NW'(n1) + NW'(1)) == n;
  assign nbr     = link_rdata.on && (link_rdata.cost != '0);

  // memory port steering
  always_comb begin
    link_we    = 1'b0;
    link_waddr = idx;
    link_wdata = '0;
    link_raddr = idx;
    r_we       = 1'b0;
    r_waddr    = ba;
    r_wdata    = b_word;
    ra_addr    = {NB'(node_a), NB'(node_b)};
    rb_addr    = {n2, j};
    case (state)
      ST_CLEAR: begin
        link_we         = 1'b1;
        link_wdata.on   = (idx[PB-1:NB] == idx[NB-1:0]);
      end
      ST_IDLE: begin
        if (accept && (s_tuser == ACT_LINK) && link_ok) begin
          link_we         = 1'b1;
          link_waddr      = {NB'(node_a), NB'(node_b)};
          link_wdata.on   = link_present;
          link_wdata.cost = link_present ? COST_BITS'(link_cost) : '0;
        end
      end
      ST_LINK2: begin
        link_we    = 1'b1;
        link_waddr = link2_addr;
        link_wdata = link2_data;
      end
      ST_PAIR_RD: begin
        link_raddr = {n1, n2};
        ra_addr    = {n1, n2};
      end
      ST_J_RD: begin
        ra_addr = {n1, j};
      end
      ST_J_EV: begin
        r_we    = upd;
        r_waddr = {n1, j};
        r_wdata = relax_word;
      end
      default: begin
      end
    endcase
    if (bv) begin
      r_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      idx        <= '0;
      bv         <= 1'b0;
      m_tvalid   <= 1'b0;
      node_count <= CFG_W'(16);
      changed    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        node_count <= cfg_wdata;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          idx <= idx + PB'(1);
          if (&idx) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              ACT_LINK: begin
                if (link_ok) begin
                  link2_addr      <= {NB'(node_b), NB'(node_a)};
                  link2_data.on   <= link_present;
                  link2_data.cost <= link_present ? COST_BITS'(link_cost) : '0;
                  state           <= ST_LINK2;
                end
              end
              ACT_CONVERGE: begin
                idx   <= '0;
                state <= ST_BUILD;
              end
              ACT_QUERY: begin
                q_ok  <= (int'(node_a) < MAX_NODES) && (int'(node_b) < MAX_NODES);
                state <= ST_QWAIT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_LINK2: begin
          state <= ST_IDLE;
        end
        ST_QWAIT: begin
          // output register is free here: accept needed it empty or emptying
          m_tvalid   <= 1'b1;
          m_tuser[0] <= q_ok && !rd_a.inf;
          m_tdata    <= q_data;
          state      <= ST_IDLE;
        end
        ST_BUILD: begin
          bv  <= 1'b1;
          ba  <= idx;
          idx <= idx + PB'(1);
          if (&idx) begin
            state <= ST_BUILD_END;
          end
        end
        ST_BUILD_END: begin
          bv      <= 1'b0;
          n1      <= '0;
          n2      <= '0;
          changed <= 1'b0;
          state   <= (n == '0) ? ST_IDLE : ST_PAIR_RD;
        end
        ST_PAIR_RD: begin
          state <= ST_PAIR_EV;
        end
        ST_PAIR_EV, ST_J_EV: begin
          if ((state == ST_PAIR_EV) && nbr) begin
            c12   <= rd_a.cost;
            hop   <= rd_a.next;
            j     <= '0;
            state <= ST_J_RD;
          end else if ((state == ST_J_EV) && !last_j) begin
            changed <= dirty;
            j       <= j + NB'(1);
            state   <= ST_J_RD;
          end else if (!last_n2) begin
            // next neighbor pair in this row
            changed <= dirty;
            n2      <= n2 + NB'(1);
            state   <= ST_PAIR_RD;
          end else if (!last_n1) begin
            changed <= dirty;
            n2      <= '0;
            n1      <= n1 + NB'(1);
            state   <= ST_PAIR_RD;
          end else begin
            // end of the sweep: repeat while anything moved
            changed <= 1'b0;
            n2      <= '0;
            n1      <= '0;
            state   <= dirty ? ST_PAIR_RD : ST_IDLE;
          end
        end
        ST_J_RD: begin
          state <= ST_J_EV;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
